>>> hdl/ils_pkg.sv
package ils_pkg;

  // Store geometry
  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths fixed by the channel format
  localparam int ACT_W  = 3;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_DROP   = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_READ   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> hdl/ils_if.sv
interface ils_in_if
  import ils_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CNT_W-1:0]  position;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, action, position, word_in, input ready);
  modport sink   (input valid, action, position, word_in, output ready);
endinterface

interface ils_out_if
  import ils_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_out;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] status;

  modport source (output valid, word_out, count, status, input ready);
  modport sink   (input valid, word_out, count, status, output ready);
endinterface

>>> hdl/ils_ram.sv
module ils_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ils_ctrl.sv
module ils_ctrl
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ils_in_if.sink            in_ch,
  ils_out_if.source         out_ch,
  output ram_req_t          ram_req,
  input  logic [DATA_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_RD_WAIT, S_SHIFT, S_DRAIN, S_FINAL, S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [ADDR_W-1:0] rd_ptr_r;
  logic [ADDR_W-1:0] end_r;
  logic              up_r;
  action_t           act_r;
  logic [CNT_W-1:0]  pos_r;
  logic [DATA_W-1:0] word_r;
  logic [WORD_W-1:0] res_word_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] out_word_r;
  logic [CNT_W-1:0]  out_cnt_r;
  status_t           out_status_r;

  logic full;
  logic pos_gt_cnt;
  logic pos_ge_cnt;
  logic accept;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign pos_gt_cnt = (pos_r > cnt_r);
  assign pos_ge_cnt = (pos_r >= cnt_r);
  assign accept     = in_ch.valid && in_ch.ready;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.word_out = out_word_r;
  assign out_ch.count    = out_cnt_r;
  assign out_ch.status   = out_status_r;

  // Memory port requests; a pending shift write owns the write port
  always_comb begin
    ram_req = '0;
    if (wr_pend_r) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = wr_addr_r;
      ram_req.wdata = ram_rdata;
    end else if (state_r == S_DECODE && !full &&
                 (act_r == ACT_APPEND || (act_r == ACT_INSERT && pos_r == cnt_r))) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = cnt_r[ADDR_W-1:0];
      ram_req.wdata = word_r;
    end else if (state_r == S_FINAL) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = pos_r[ADDR_W-1:0];
      ram_req.wdata = word_r;
    end
    if (state_r == S_DECODE && act_r == ACT_READ && !pos_ge_cnt) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = pos_r[ADDR_W-1:0];
    end else if (state_r == S_SHIFT) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      wr_pend_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r   <= action_t'(in_ch.action);
            pos_r   <= in_ch.position;
            word_r  <= in_ch.word_in[DATA_W-1:0];
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_word_r   <= '0;
          res_status_r <= ST_OK;
          state_r      <= S_DONE;
          unique case (act_r)
            ACT_APPEND: begin
              if (full) res_status_r <= ST_FULL;
              else      cnt_r <= cnt_r + 1'b1;
            end
            ACT_DROP: begin
              if (cnt_r == '0) res_status_r <= ST_EMPTY;
              else             cnt_r <= cnt_r - 1'b1;
            end
            ACT_INSERT: begin
              if (pos_gt_cnt) begin
                res_status_r <= ST_RANGE;
              end else if (full) begin
                res_status_r <= ST_FULL;
              end else begin
                cnt_r <= cnt_r + 1'b1;
                if (pos_r != cnt_r) begin
                  rd_ptr_r <= ADDR_W'(cnt_r - 1'b1);
                  end_r    <= pos_r[ADDR_W-1:0];
                  up_r     <= 1'b1;
                  state_r  <= S_SHIFT;
                end
              end
            end
            ACT_ERASE: begin
              if (pos_ge_cnt) begin
                res_status_r <= ST_RANGE;
              end else begin
                cnt_r <= cnt_r - 1'b1;
                if (pos_r != cnt_r - 1'b1) begin
                  rd_ptr_r <= ADDR_W'(pos_r + 1'b1);
                  end_r    <= ADDR_W'(cnt_r - 1'b1);
                  up_r     <= 1'b0;
                  state_r  <= S_SHIFT;
                end
              end
            end
            ACT_READ: begin
              if (pos_ge_cnt) res_status_r <= ST_RANGE;
              else            state_r <= S_RD_WAIT;
            end
            ACT_CLEAR: begin
              cnt_r <= '0;
            end
            default: begin
            end
          endcase
        end
        S_RD_WAIT: begin
          res_word_r <= WORD_W'(ram_rdata);
          state_r    <= S_DONE;
        end
        S_SHIFT: begin
          // read issued this cycle lands one place over next cycle
          wr_pend_r <= 1'b1;
          wr_addr_r <= up_r ? rd_ptr_r + 1'b1 : rd_ptr_r - 1'b1;
          if (rd_ptr_r == end_r) begin
            state_r <= S_DRAIN;
          end else begin
            rd_ptr_r <= up_r ? rd_ptr_r - 1'b1 : rd_ptr_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= up_r ? S_FINAL : S_DONE;
        end
        S_FINAL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_word_r   <= res_word_r;
            out_cnt_r    <= cnt_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re && ram_req.waddr == ram_req.raddr))
    else $error("read and write hit the same entry");

  a_pend_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(wr_pend_r) |-> $past(state_r == S_SHIFT))
    else $error("shift write without a shift read");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DECODE)
    else $error("accepted transfer not decoded");

  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not posted from a free output slot");

endmodule

>>> hdl/indexed_list_store.sv
// Ordered list of up to DEPTH words held in a one-write, one-read synchronous
// memory, with a count of the words in use. Each transfer on in_ch asks for one of
// append, drop last, insert, erase, read or clear and yields exactly one transfer on
// out_ch carrying the word read (zero unless a read succeeds), the count after the
// request and a status (ok, index out of range, full, empty); a failed request leaves
// the list untouched. One request is worked at a time. An insert or erase moves the
// later elements one place up (insert) or down (erase); an insert at the count or an
// erase of the last element moves nothing. The memory's single write port moves one
// element per cycle, so the time an insert or erase takes grows with the number of
// elements moved. The next request can be taken as soon as the result is posted to
// the output register, which holds it while out_ch stalls. Clear only zeroes the
// count; no clearing pass runs after reset.
module indexed_list_store
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // Sequencer: decode, shift loop and result register
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Element store
  ils_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
